// File: hw/rtl/yenc_pkg.sv
// Package: opcodes, result kinds, decode phases and the CRC-32 byte step for the yEnc decoder.
package yenc_pkg;

	localparam int COUNT_BITS = 24;

	localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [7:0]  ESC_CHAR = 8'h3D;
	localparam logic [7:0]  OFS_PLAIN = 8'd42;
	localparam logic [7:0]  OFS_ESC = 8'd106;
	localparam logic [15:0] ERR_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		OP_DATA       = 3'd0,
		OP_FILE_BEGIN = 3'd1,
		OP_PART_BEGIN = 3'd2,
		OP_PART_END   = 3'd3,
		OP_RESTART    = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_BEGIN = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_WAIT   = 2'd1,
		PH_DECODE = 2'd2
	} phase_t;

	localparam logic [1:0] ADDR_PARTIAL = 2'd0;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: hw/rtl/yenc_decoder_with_crc_check.sv
// Top level: yEnc byte decoder with file and part CRC-32, offset and size checks.
// Latency: a result is visible in the cycle after its input transfer.
// Throughput: one input item per cycle; the decode and CRC byte step sit in one stage.
// The input is held off only while a result waits and out_ready is low.
// Reset: arst_n async clears all but result data regs; CRCs all ones, counters zero.
module yenc_decoder_with_crc_check import yenc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [7:0]  data_byte,
	input  logic        multipart,
	input  logic [31:0] begin_offset,
	input  logic        file_crc_given,
	input  logic [31:0] file_crc_expected,
	input  logic        part_crc_given,
	input  logic [31:0] part_crc_expected,
	input  logic        size_given,
	input  logic [23:0] part_size_expected,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  decoded_byte,
	output logic        file_crc_bad,
	output logic        part_crc_bad,
	output logic        size_bad,
	output logic        position_bad,
	output logic        seek_request,
	output logic [31:0] seek_position,
	output logic [15:0] error_count
);

	logic                  partial_mode_q;
	logic [31:0]           file_crc_q, part_crc_q, file_crc_start_q, file_pos_q;
	logic [COUNT_BITS-1:0] byte_cnt_q;
	phase_t                phase_q;
	logic                  esc_q;
	logic [15:0]           errors_q;

	logic [31:0]           file_crc_d, part_crc_d, file_crc_start_d, file_pos_d;
	logic [COUNT_BITS-1:0] byte_cnt_d;
	phase_t                phase_d;
	logic                  esc_d;
	logic [15:0]           errors_d;

	logic        res_fire;
	kind_t       res_kind;
	logic [7:0]  res_byte;
	logic        res_fbad, res_pbad, res_sbad, res_posbad, res_seek;
	logic [31:0] res_seek_pos;

	logic        in_xfer;
	logic [7:0]  dec_byte;
	logic [31:0] want_pos;
	logic [1:0]  n_err;
	logic [17:0] err_sum;
	logic        fbad, pbad, sbad;

	logic        valid_q;
	kind_t       kind_q;
	logic [7:0]  byte_q;
	logic        fbad_q, pbad_q, sbad_q, posbad_q, seek_q;
	logic [31:0] seek_pos_q;
	logic [15:0] errcnt_q;

	assign pready = 1'b1;
	assign prdata = {31'd0, partial_mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == ADDR_PARTIAL) begin
			partial_mode_q <= pwdata[0];
		end
	end

	assign in_ready = !valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	assign dec_byte = data_byte - (esc_q ? OFS_ESC : OFS_PLAIN);
	assign want_pos = begin_offset - 32'd1;
	assign fbad = file_crc_given && !partial_mode_q
		&& ((file_crc_q ^ CRC_ONES) != file_crc_expected);
	assign pbad = part_crc_given && ((part_crc_q ^ CRC_ONES) != part_crc_expected);
	assign sbad = size_given && (32'(part_size_expected) != 32'(byte_cnt_q));

	always_comb begin
		file_crc_d       = file_crc_q;
		part_crc_d       = part_crc_q;
		file_crc_start_d = file_crc_start_q;
		file_pos_d       = file_pos_q;
		byte_cnt_d       = byte_cnt_q;
		phase_d          = phase_q;
		esc_d            = 1'b0;
		n_err            = 2'd0;
		res_fire         = 1'b0;
		res_kind         = KIND_BYTE;
		res_byte         = 8'd0;
		res_fbad         = 1'b0;
		res_pbad         = 1'b0;
		res_sbad         = 1'b0;
		res_posbad       = 1'b0;
		res_seek         = 1'b0;
		res_seek_pos     = 32'd0;
		unique case (op_t'(op))
			OP_DATA: begin
				if (phase_q == PH_DECODE) begin
					if (!esc_q && data_byte == ESC_CHAR) begin
						esc_d = 1'b1;
					end else begin
						file_crc_d = crc_byte(file_crc_q, dec_byte);
						part_crc_d = crc_byte(part_crc_q, dec_byte);
						byte_cnt_d = byte_cnt_q + COUNT_BITS'(1);
						res_fire   = 1'b1;
						res_byte   = dec_byte;
					end
				end
			end
			OP_FILE_BEGIN: begin
				phase_d = multipart ? PH_WAIT : PH_DECODE;
			end
			OP_PART_BEGIN: begin
				res_fire         = 1'b1;
				res_kind         = KIND_BEGIN;
				part_crc_d       = CRC_ONES;
				file_crc_start_d = file_crc_q;
				if (want_pos != file_pos_q) begin
					if (partial_mode_q) begin
						file_pos_d   = want_pos;
						res_seek     = 1'b1;
						res_seek_pos = want_pos;
					end else begin
						res_posbad = 1'b1;
						n_err      = 2'd1;
					end
				end
				phase_d = PH_DECODE;
			end
			OP_PART_END: begin
				res_fire   = 1'b1;
				res_kind   = KIND_END;
				res_fbad   = fbad;
				res_pbad   = pbad;
				res_sbad   = sbad;
				n_err      = 2'(fbad) + 2'(pbad) + 2'(sbad);
				file_pos_d = file_pos_q + 32'(byte_cnt_q);
				byte_cnt_d = '0;
				phase_d    = PH_IDLE;
			end
			OP_RESTART: begin
				res_fire     = 1'b1;
				res_kind     = KIND_END;
				part_crc_d   = CRC_ONES;
				file_crc_d   = file_crc_start_q;
				byte_cnt_d   = '0;
				phase_d      = PH_DECODE;
				res_seek     = 1'b1;
				res_seek_pos = file_pos_q;
			end
			default: begin
				esc_d = esc_q;
			end
		endcase
		err_sum  = 18'(errors_q) + 18'(n_err);
		errors_d = (err_sum > 18'(ERR_MAX)) ? ERR_MAX : err_sum[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_crc_q       <= CRC_ONES;
			part_crc_q       <= CRC_ONES;
			file_crc_start_q <= CRC_ONES;
			file_pos_q       <= '0;
			byte_cnt_q       <= '0;
			phase_q          <= PH_IDLE;
			esc_q            <= 1'b0;
			errors_q         <= '0;
		end else if (in_xfer) begin
			file_crc_q       <= file_crc_d;
			part_crc_q       <= part_crc_d;
			file_crc_start_q <= file_crc_start_d;
			file_pos_q       <= file_pos_d;
			byte_cnt_q       <= byte_cnt_d;
			phase_q          <= phase_d;
			esc_q            <= esc_d;
			errors_q         <= errors_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid && res_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && res_fire) begin
			kind_q     <= res_kind;
			byte_q     <= res_byte;
			fbad_q     <= res_fbad;
			pbad_q     <= res_pbad;
			sbad_q     <= res_sbad;
			posbad_q   <= res_posbad;
			seek_q     <= res_seek;
			seek_pos_q <= res_seek_pos;
			errcnt_q   <= errors_d;
		end
	end

	assign out_valid     = valid_q;
	assign kind          = kind_q;
	assign decoded_byte  = byte_q;
	assign file_crc_bad  = fbad_q;
	assign part_crc_bad  = pbad_q;
	assign size_bad      = sbad_q;
	assign position_bad  = posbad_q;
	assign seek_request  = seek_q;
	assign seek_position = seek_pos_q;
	assign error_count   = errcnt_q;

endmodule

// File: hw/rtl/yenc_checker.sv
// Checker: port-level properties of the yEnc decoder, bound to the top level.
module yenc_checker import yenc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic        file_crc_bad,
	input logic        part_crc_bad,
	input logic        size_bad,
	input logic        position_bad,
	input logic        seek_request,
	input logic [31:0] seek_position
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(seek_position))
		else $error("result dropped or changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_BYTE |-> !(file_crc_bad || part_crc_bad || size_bad
			|| position_bad || seek_request))
		else $error("flags set on decoded byte");

	a_seek_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !seek_request |-> seek_position == 32'd0)
		else $error("seek position without seek request");

	a_begin_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_BEGIN |-> !(file_crc_bad || part_crc_bad || size_bad)
			&& !(position_bad && seek_request))
		else $error("bad flags on part begin report");

endmodule

bind yenc_decoder_with_crc_check yenc_checker u_yenc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.kind          (kind),
	.file_crc_bad  (file_crc_bad),
	.part_crc_bad  (part_crc_bad),
	.size_bad      (size_bad),
	.position_bad  (position_bad),
	.seek_request  (seek_request),
	.seek_position (seek_position)
);

// File: sim/yenc_decode_checker.sv
`timescale 1ns / 1ps
// Checker for the yEnc decoder: tracks decode state from input transfers and compares outputs.
module yenc_decode_checker import yenc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  op,
	input  logic [7:0]  data_byte,
	input  logic        multipart,
	input  logic [31:0] begin_offset,
	input  logic        file_crc_given,
	input  logic [31:0] file_crc_expected,
	input  logic        part_crc_given,
	input  logic [31:0] part_crc_expected,
	input  logic        size_given,
	input  logic [23:0] part_size_expected,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  decoded_byte,
	input  logic        file_crc_bad,
	input  logic        part_crc_bad,
	input  logic        size_bad,
	input  logic        position_bad,
	input  logic        seek_request,
	input  logic [31:0] seek_position,
	input  logic [15:0] error_count,
	output int          fail_count,
	output int          pending,
	output logic [31:0] file_crc_now,
	output logic [31:0] part_crc_now,
	output logic [23:0] part_bytes_now,
	output logic [31:0] file_pos_now
);

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  dbyte;
		logic        file_bad;
		logic        part_bad;
		logic        size_bad;
		logic        pos_bad;
		logic        seek;
		logic [31:0] seek_pos;
		logic [15:0] errs;
	} dec_out_t;

	dec_out_t    decoder_output_q[$];
	logic        partial_on;
	logic [31:0] file_crc;
	logic [31:0] part_crc;
	logic [31:0] crc_at_part;
	logic [23:0] byte_cnt;
	logic [31:0] file_pos;
	phase_t      phase;
	logic        esc;
	logic [15:0] errs;

	assign file_crc_now   = file_crc ^ CRC_ONES;
	assign part_crc_now   = part_crc ^ CRC_ONES;
	assign part_bytes_now = byte_cnt;
	assign file_pos_now   = file_pos;

	function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] d);
		logic [31:0] r;
		int k;
		r = acc;
		for (k = 0; k < 8; k++) begin
			if (r[0] ^ d[k]) begin
				r = {1'b0, r[31:1]} ^ CRC_POLY;
			end else begin
				r = {1'b0, r[31:1]};
			end
		end
		return r;
	endfunction

	task count_error();
		if (errs != ERR_MAX) begin
			errs++;
		end
	endtask

	task check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= 40) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		end
	endtask

	task check_output();
		dec_out_t want;
		if (decoder_output_q.size() == 0) begin
			fail_count++;
			if (fail_count <= 40) begin
				$display("%0t: output transfer with nothing outstanding, %s %0h byte %0h",
					$time, "expected none, actual kind", kind, decoded_byte);
			end
			return;
		end
		want = decoder_output_q.pop_front();
		check_field("kind", 32'(want.kind), 32'(kind));
		check_field("decoded_byte", 32'(want.dbyte), 32'(decoded_byte));
		check_field("file_crc_bad", 32'(want.file_bad), 32'(file_crc_bad));
		check_field("part_crc_bad", 32'(want.part_bad), 32'(part_crc_bad));
		check_field("size_bad", 32'(want.size_bad), 32'(size_bad));
		check_field("position_bad", 32'(want.pos_bad), 32'(position_bad));
		check_field("seek_request", 32'(want.seek), 32'(seek_request));
		check_field("seek_position", want.seek_pos, seek_position);
		check_field("error_count", 32'(want.errs), 32'(error_count));
	endtask

	task decode_item();
		dec_out_t r;
		logic [7:0] d;
		logic [31:0] want_pos;
		r = '0;
		if (op == OP_DATA) begin
			if (phase != PH_DECODE) begin
				esc = 1'b0;
			end else if (!esc && data_byte == ESC_CHAR) begin
				esc = 1'b1;
			end else begin
				d = esc ? data_byte - OFS_ESC : data_byte - OFS_PLAIN;
				esc = 1'b0;
				file_crc = crc32_step(file_crc, d);
				part_crc = crc32_step(part_crc, d);
				byte_cnt = byte_cnt + 24'd1;
				r.kind = KIND_BYTE;
				r.dbyte = d;
				r.errs = errs;
				decoder_output_q.push_back(r);
			end
		end else if (op <= OP_RESTART) begin
			esc = 1'b0;
			case (op)
				OP_FILE_BEGIN: begin
					phase = multipart ? PH_WAIT : PH_DECODE;
				end
				OP_PART_BEGIN: begin
					r.kind = KIND_BEGIN;
					part_crc = CRC_ONES;
					crc_at_part = file_crc;
					want_pos = begin_offset - 32'd1;
					if (want_pos != file_pos) begin
						if (partial_on) begin
							file_pos = want_pos;
							r.seek = 1'b1;
							r.seek_pos = want_pos;
						end else begin
							r.pos_bad = 1'b1;
							count_error();
						end
					end
					phase = PH_DECODE;
					r.errs = errs;
					decoder_output_q.push_back(r);
				end
				OP_PART_END: begin
					r.kind = KIND_END;
					if (file_crc_given && !partial_on && file_crc_now != file_crc_expected) begin
						r.file_bad = 1'b1;
						count_error();
					end
					if (part_crc_given && part_crc_now != part_crc_expected) begin
						r.part_bad = 1'b1;
						count_error();
					end
					if (size_given && part_size_expected != byte_cnt) begin
						r.size_bad = 1'b1;
						count_error();
					end
					file_pos = file_pos + {8'd0, byte_cnt};
					byte_cnt = '0;
					phase = PH_IDLE;
					r.errs = errs;
					decoder_output_q.push_back(r);
				end
				default: begin
					r.kind = KIND_END;
					part_crc = CRC_ONES;
					file_crc = crc_at_part;
					byte_cnt = '0;
					phase = PH_DECODE;
					r.seek = 1'b1;
					r.seek_pos = file_pos;
					r.errs = errs;
					decoder_output_q.push_back(r);
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decoder_output_q.delete();
			partial_on = 1'b0;
			file_crc = CRC_ONES;
			part_crc = CRC_ONES;
			crc_at_part = CRC_ONES;
			byte_cnt = '0;
			file_pos = '0;
			phase = PH_IDLE;
			esc = 1'b0;
			errs = '0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				check_output();
			end
			if (psel && penable && pwrite && pready && paddr == ADDR_PARTIAL) begin
				partial_on = pwdata[0];
			end
			if (in_valid && in_ready) begin
				decode_item();
			end
			pending = decoder_output_q.size();
		end
	end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the yEnc decoder: clock, reset, stimulus, receiver stalls and verdict.
module tb_top;
	import yenc_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_HOLD = 300;
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST = 3'd7;

	typedef struct {
		logic [2:0]  op;
		logic [7:0]  data_byte;
		logic        multipart;
		logic [31:0] begin_offset;
		logic        file_crc_given;
		logic [31:0] file_crc_expected;
		logic        part_crc_given;
		logic [31:0] part_crc_expected;
		logic        size_given;
		logic [23:0] part_size_expected;
	} yenc_item_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  op;
	logic [7:0]  data_byte;
	logic        multipart;
	logic [31:0] begin_offset;
	logic        file_crc_given;
	logic [31:0] file_crc_expected;
	logic        part_crc_given;
	logic [31:0] part_crc_expected;
	logic        size_given;
	logic [23:0] part_size_expected;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [7:0]  decoded_byte;
	logic        file_crc_bad;
	logic        part_crc_bad;
	logic        size_bad;
	logic        position_bad;
	logic        seek_request;
	logic [31:0] seek_position;
	logic [15:0] error_count;
	int          fail_count;
	int          pending;
	logic [31:0] file_crc_now;
	logic [31:0] part_crc_now;
	logic [23:0] part_bytes_now;
	logic [31:0] file_pos_now;

	int items_sent;
	int idle_cycles;
	bit steady;

	yenc_decoder_with_crc_check u_dut (.*);
	yenc_decode_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic yenc_item_t random_item();
		yenc_item_t it;
		it.op = 3'($urandom_range(0, 7));
		it.data_byte = 8'($urandom);
		it.multipart = 1'($urandom);
		it.begin_offset = $urandom;
		it.file_crc_given = 1'($urandom);
		it.file_crc_expected = $urandom;
		it.part_crc_given = 1'($urandom);
		it.part_crc_expected = $urandom;
		it.size_given = 1'($urandom);
		it.part_size_expected = 24'($urandom);
		return it;
	endfunction

	task automatic send(input yenc_item_t it);
		int gap;
		gap = 0;
		if (!steady) begin
			case ($urandom_range(0, 19))
				0: gap = $urandom_range(8, 40);
				1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
				default: gap = 0;
			endcase
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		op <= it.op;
		data_byte <= it.data_byte;
		multipart <= it.multipart;
		begin_offset <= it.begin_offset;
		file_crc_given <= it.file_crc_given;
		file_crc_expected <= it.file_crc_expected;
		part_crc_given <= it.part_crc_given;
		part_crc_expected <= it.part_crc_expected;
		size_given <= it.size_given;
		part_size_expected <= it.part_size_expected;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_op(input logic [2:0] code);
		yenc_item_t it;
		it = random_item();
		it.op = code;
		send(it);
	endtask

	task automatic send_data(input logic [7:0] b);
		yenc_item_t it;
		it = random_item();
		it.op = OP_DATA;
		it.data_byte = b;
		send(it);
	endtask

	task automatic send_file_begin(input logic multi);
		yenc_item_t it;
		it = random_item();
		it.op = OP_FILE_BEGIN;
		it.multipart = multi;
		send(it);
	endtask

	task automatic send_part_begin(input logic [31:0] offset);
		yenc_item_t it;
		it = random_item();
		it.op = OP_PART_BEGIN;
		it.begin_offset = offset;
		send(it);
	endtask

	// given and good: bit 0 file crc, bit 1 part crc, bit 2 size
	task automatic send_part_end(input logic [2:0] given, input logic [2:0] good);
		yenc_item_t it;
		it = random_item();
		it.op = OP_PART_END;
		it.file_crc_given = given[0];
		it.part_crc_given = given[1];
		it.size_given = given[2];
		it.file_crc_expected = good[0] ? file_crc_now :
			file_crc_now ^ (32'd1 << $urandom_range(0, 31));
		it.part_crc_expected = good[1] ? part_crc_now :
			part_crc_now ^ (32'd1 << $urandom_range(0, 31));
		it.part_size_expected = good[2] ? part_bytes_now :
			part_bytes_now ^ (24'd1 << $urandom_range(0, 23));
		send(it);
	endtask

	task automatic send_encoded(input logic [7:0] d);
		logic [7:0] raw;
		raw = d + OFS_PLAIN;
		if (raw == 8'h00 || raw == 8'h0A || raw == 8'h0D || raw == ESC_CHAR ||
			$urandom_range(0, 9) == 0) begin
			send_data(ESC_CHAR);
			send_data(raw + 8'd64);
		end else begin
			send_data(raw);
		end
	endtask

	task automatic write_partial(input logic v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_PARTIAL;
		pwdata <= {31'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_files(input int quota);
		int stop_at;
		int parts;
		int nbytes;
		int p;
		int k;
		logic multi;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6)) send_op(3'($urandom_range(0, 7)));
			end else begin
				multi = 1'($urandom);
				send_file_begin(multi);
				parts = multi ? $urandom_range(1, 3) : 1;
				for (p = 0; p < parts; p++) begin
					if (multi) begin
						if ($urandom_range(0, 7) == 0) begin
							send_data(8'($urandom));
						end
						send_part_begin(($urandom_range(0, 4) == 0) ? $urandom :
							file_pos_now + 32'd1);
					end
					nbytes = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 80) :
						$urandom_range(0, 12);
					for (k = 0; k < nbytes; k++) begin
						send_encoded(8'($urandom));
						if ($urandom_range(0, 60) == 0) begin
							send_op(OP_RESTART);
						end
					end
					if ($urandom_range(0, 11) == 0) begin
						send_op(3'($urandom_range(OP_FILE_BEGIN, OP_SPARE_LAST)));
					end
					send_part_end(3'($urandom_range(0, 7)), {$urandom_range(0, 4) != 0,
						$urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0});
				end
			end
		end
		steady = 1'b0;
	endtask

	initial begin : receiver
		int run;
		bit hold_done;
		out_ready = 1'b0;
		run = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && items_sent >= 600) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				run = LONG_HOLD;
			end else if (run > 0) begin
				run--;
			end else begin
				case ($urandom_range(0, 19))
					0: begin
						out_ready <= 1'b0;
						run = $urandom_range(10, 40);
					end
					1, 2, 3, 4, 5: begin
						out_ready <= 1'b0;
						run = $urandom_range(0, 3);
					end
					default: begin
						out_ready <= 1'b1;
						run = $urandom_range(0, 30);
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("yenc_decoder_with_crc_check test failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		op = '0;
		data_byte = '0;
		multipart = 1'b0;
		begin_offset = '0;
		file_crc_given = 1'b0;
		file_crc_expected = '0;
		part_crc_given = 1'b0;
		part_crc_expected = '0;
		size_given = 1'b0;
		part_size_expected = '0;
		items_sent = 0;
		idle_cycles = 0;
		steady = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_partial(1'b0);

		send_file_begin(1'b0);
		send_data(8'h00);
		send_data(8'hFF);
		send_data(ESC_CHAR);
		send_data(ESC_CHAR);
		send_data(ESC_CHAR);
		send_data(8'h00);
		send_data(ESC_CHAR);
		send_data(8'hFF);
		send_data(OFS_PLAIN);
		send_data(ESC_CHAR);
		send_op(OP_RESTART);
		send_data(8'h41);
		send_part_end(3'b111, 3'b111);
		send_data(ESC_CHAR);
		send_data(8'h50);
		send_file_begin(1'b1);
		send_data(8'h20);
		send_part_begin(file_pos_now + 32'd1);
		send_data(8'h80);
		send_part_end(3'b111, 3'b000);
		send_part_begin(32'd0);
		send_part_begin(32'hFFFF_FFFF);
		send_op(OP_SPARE_FIRST);
		send_op(OP_SPARE_LAST);
		send_part_end(3'b000, 3'b111);
		settle();

		write_partial(1'b1);
		run_files(400);
		settle();
		write_partial(1'b0);
		run_files(400);
		settle();
		write_partial(1'b1);
		run_files(400);
		settle();
		write_partial(1'b0);
		run_files(400);
		settle();
		repeat (4) @(negedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("yenc_decoder_with_crc_check test passed");
		end else begin
			$display("yenc_decoder_with_crc_check test failed");
		end
		$finish;
	end

endmodule
